// ===== hw/rtl/hsvrgb_pkg.sv =====
// Package for the HSV to RGB converter with LED channel ordering.
// Holds field widths, arithmetic constants, payload structs and code enums.
// No dependencies; the interfaces and the top level import it.
package hsvrgb_pkg;

  localparam int unsigned HueW   = 9;
  localparam int unsigned PctW   = 7;
  localparam int unsigned GrpW   = 3;
  localparam int unsigned LevelW = 8;
  localparam int unsigned OrderW = 3;
  localparam int unsigned TW     = 6;   // triangle term 0..60
  localparam int unsigned ProdW  = 14;  // s*v and m, up to 10000
  localparam int unsigned SumW   = 20;  // sums scaled by 60, up to 600000
  localparam int unsigned RecipW = 21;
  localparam int unsigned EstW   = SumW + RecipW;
  localparam int unsigned NumW   = 25;  // sum*17 and remainder work width
  localparam int unsigned RecipShift = 32;

  localparam logic [HueW-1:0]  HUE_LIMIT  = 9'd360;
  localparam logic [HueW-1:0]  DEG_60     = 9'd60;
  localparam logic [HueW-1:0]  DEG_120    = 9'd120;
  localparam logic [HueW-1:0]  DEG_180    = 9'd180;
  localparam logic [HueW-1:0]  DEG_240    = 9'd240;
  localparam logic [HueW-1:0]  DEG_300    = 9'd300;
  localparam logic [PctW-1:0]  PCT_LIMIT  = 7'd100;
  localparam logic [ProdW-1:0] PCT_SCALE  = 14'd100;
  localparam logic [SumW-1:0]  SECTOR_MUL = 20'd60;
  localparam logic [SumW-1:0]  FULL_MUL   = 20'd6000;

  // level = floor(sum*255/600000) = floor(sum*17/40000).
  // The reciprocal estimate floor(sum*RECIP_MULT / 2^32) is q or q-1.
  localparam logic [RecipW-1:0] RECIP_MULT = 21'd1825361;
  localparam logic [NumW-1:0]   LEVEL_DIV  = 25'd40000;

  typedef enum logic [OrderW-1:0] {
    ORDER_RGB = 3'd0,
    ORDER_RBG = 3'd1,
    ORDER_GRB = 3'd2,
    ORDER_GBR = 3'd3,
    ORDER_BGR = 3'd4,
    ORDER_BRG = 3'd5
  } order_e;

  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueW-1:0] hue_degrees;
    logic [PctW-1:0] saturation_pct;
    logic [PctW-1:0] value_pct;
    logic [GrpW-1:0] led_index;
  } hsv_item_t;

  typedef struct packed {
    logic              range_error;
    logic [GrpW-1:0]   led_group;
    logic [LevelW-1:0] red_level;
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] blue_level;
    logic [LevelW-1:0] slot0_level;
    logic [LevelW-1:0] slot1_level;
    logic [LevelW-1:0] slot2_level;
  } rgb_item_t;

endpackage

// ===== hw/rtl/hsvrgb_in_if.sv =====
// Valid/ready channel carrying one HSV item per beat.
// Depends on hsvrgb_pkg for the payload struct.
interface hsvrgb_in_if import hsvrgb_pkg::*; ();
  logic      valid;
  logic      ready;
  hsv_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/hsvrgb_out_if.sv =====
// Valid/ready channel carrying one converted RGB item per beat.
// Depends on hsvrgb_pkg for the payload struct.
interface hsvrgb_out_if import hsvrgb_pkg::*; ();
  logic      valid;
  logic      ready;
  rgb_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/hsv_to_rgb_channel_order_top.sv =====
// Channel     | Dir | Kind        | Payload
// hsv_i       | in  | valid/ready | hue, saturation, value, LED index
// rgb_o       | out | valid/ready | error flag, group, RGB and ordered slot levels
// cfg_*_i     | in  | write only  | channel order register
//
// One beat is accepted per cycle unless the pipeline is full and rgb_o is not ready;
// each result passes through the register stages below in order.
// The pipeline has four register stages: sector and s*v product, sums,
// reciprocal multiply, remainder correction with slot ordering.
// Each stage holds while the one after it is full and stalled, so bubbles fill up.
// Reset clears all valid bits and sets the channel order to RGB.
// Depends on hsvrgb_pkg, hsvrgb_in_if and hsvrgb_out_if.
module hsv_to_rgb_channel_order_top import hsvrgb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  hsvrgb_in_if.sink           hsv_i,
  hsvrgb_out_if.source        rgb_o,
  input  logic                cfg_we_i,
  input  logic [OrderW-1:0]   cfg_wdata_i
);

  logic [OrderW-1:0] order_q;

  // Stage valid bits and stage enables.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || rgb_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign hsv_i.ready = en1;

  // Stage 1 registers.
  logic             err1_q;
  logic [GrpW-1:0]  grp1_q;
  logic [ProdW-1:0] c1_q;
  logic [PctW-1:0]  val1_q;
  logic [TW-1:0]    t1_q;
  sector_e          sec1_q;

  // Stage 2 registers; index 0 red, 1 green, 2 blue.
  logic                     err2_q;
  logic [GrpW-1:0]          grp2_q;
  logic [2:0][SumW-1:0]     sum2_q;

  // Stage 3 registers.
  logic                     err3_q;
  logic [GrpW-1:0]          grp3_q;
  logic [2:0][SumW-1:0]     sum3_q;
  logic [2:0][LevelW-1:0]   est3_q;

  // Output register.
  rgb_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RGB;
    end else if (cfg_we_i) begin
      order_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= hsv_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------- Stage A: range check, sector, triangle, c = s*v
  logic [HueW-1:0]  hue_a;
  logic [PctW-1:0]  sat_a;
  logic [PctW-1:0]  val_a;
  logic             err_a;
  logic [ProdW-1:0] c_a;
  logic [HueW-1:0]  base_a;
  logic [HueW-1:0]  hm_a;
  logic [HueW-1:0]  tfull_a;
  sector_e          sec_a;

  always_comb begin
    hue_a = hsv_i.payload.hue_degrees;
    sat_a = hsv_i.payload.saturation_pct;
    val_a = hsv_i.payload.value_pct;
    err_a = (hue_a >= HUE_LIMIT) || (sat_a > PCT_LIMIT) || (val_a > PCT_LIMIT);
    c_a   = {{(ProdW-PctW){1'b0}}, sat_a} * {{(ProdW-PctW){1'b0}}, val_a};
    if (hue_a < DEG_60) begin
      sec_a  = SEC_R_TO_Y;
      base_a = '0;
    end else if (hue_a < DEG_120) begin
      sec_a  = SEC_Y_TO_G;
      base_a = '0;
    end else if (hue_a < DEG_180) begin
      sec_a  = SEC_G_TO_C;
      base_a = DEG_120;
    end else if (hue_a < DEG_240) begin
      sec_a  = SEC_C_TO_B;
      base_a = DEG_120;
    end else if (hue_a < DEG_300) begin
      sec_a  = SEC_B_TO_M;
      base_a = DEG_240;
    end else begin
      sec_a  = SEC_M_TO_R;
      base_a = DEG_240;
    end
    // hue mod 120, then the triangle 60 - |hm - 60|.
    hm_a = hue_a - base_a;
    if (hm_a < DEG_60) begin
      tfull_a = hm_a;
    end else begin
      tfull_a = DEG_120 - hm_a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && hsv_i.valid) begin
      err1_q <= err_a;
      grp1_q <= hsv_i.payload.led_index;
      c1_q   <= c_a;
      val1_q <= val_a;
      t1_q   <= tfull_a[TW-1:0];
      sec1_q <= sec_a;
    end
  end

  // ---------------- Stage B: m, scaled sums, sector selection
  logic [ProdW-1:0] m_b;
  logic [SumW-1:0]  cm_b;
  logic [SumW-1:0]  xm_b;
  logic [SumW-1:0]  mm_b;
  logic [2:0][SumW-1:0] sum_b;

  always_comb begin
    m_b  = ({{(ProdW-PctW){1'b0}}, val1_q} * PCT_SCALE) - c1_q;
    mm_b = {{(SumW-ProdW){1'b0}}, m_b} * SECTOR_MUL;
    cm_b = {{(SumW-PctW){1'b0}}, val1_q} * FULL_MUL;
    xm_b = ({{(SumW-ProdW){1'b0}}, c1_q} * {{(SumW-TW){1'b0}}, t1_q}) + mm_b;
    case (sec1_q)
      SEC_R_TO_Y: sum_b = {mm_b, xm_b, cm_b};
      SEC_Y_TO_G: sum_b = {mm_b, cm_b, xm_b};
      SEC_G_TO_C: sum_b = {xm_b, cm_b, mm_b};
      SEC_C_TO_B: sum_b = {cm_b, xm_b, mm_b};
      SEC_B_TO_M: sum_b = {cm_b, mm_b, xm_b};
      default:    sum_b = {xm_b, mm_b, cm_b};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      err2_q <= err1_q;
      grp2_q <= grp1_q;
      sum2_q <= sum_b;
    end
  end

  // ---------------- Stage C: reciprocal estimate of sum*17/40000
  logic [2:0][EstW-1:0] prod_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_c[k] = {{RecipW{1'b0}}, sum2_q[k]} * {{SumW{1'b0}}, RECIP_MULT};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      err3_q <= err2_q;
      grp3_q <= grp2_q;
      sum3_q <= sum2_q;
      for (int k = 0; k < 3; k++) begin
        est3_q[k] <= prod_c[k][RecipShift +: LevelW];
      end
    end
  end

  // ---------------- Stage D: remainder correction, error masking, ordering
  logic [2:0][NumW-1:0]   num_d;
  logic [2:0][NumW-1:0]   rem_d;
  logic [2:0][LevelW-1:0] lvl_d;
  rgb_item_t              res_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_d[k] = ({{(NumW-SumW){1'b0}}, sum3_q[k]} << 4)
               + {{(NumW-SumW){1'b0}}, sum3_q[k]};
      rem_d[k] = num_d[k] - ({{(NumW-LevelW){1'b0}}, est3_q[k]} * LEVEL_DIV);
      if (err3_q) begin
        lvl_d[k] = '0;
      end else if (rem_d[k] >= LEVEL_DIV) begin
        lvl_d[k] = est3_q[k] + LevelW'(1);
      end else begin
        lvl_d[k] = est3_q[k];
      end
    end
    res_d.range_error = err3_q;
    res_d.led_group   = grp3_q;
    res_d.red_level   = lvl_d[0];
    res_d.green_level = lvl_d[1];
    res_d.blue_level  = lvl_d[2];
    case (order_q)
      ORDER_RGB: begin
        res_d.slot0_level = lvl_d[0];
        res_d.slot1_level = lvl_d[1];
        res_d.slot2_level = lvl_d[2];
      end
      ORDER_RBG: begin
        res_d.slot0_level = lvl_d[0];
        res_d.slot1_level = lvl_d[2];
        res_d.slot2_level = lvl_d[1];
      end
      ORDER_GRB: begin
        res_d.slot0_level = lvl_d[1];
        res_d.slot1_level = lvl_d[0];
        res_d.slot2_level = lvl_d[2];
      end
      ORDER_GBR: begin
        res_d.slot0_level = lvl_d[1];
        res_d.slot1_level = lvl_d[2];
        res_d.slot2_level = lvl_d[0];
      end
      ORDER_BGR: begin
        res_d.slot0_level = lvl_d[2];
        res_d.slot1_level = lvl_d[1];
        res_d.slot2_level = lvl_d[0];
      end
      default: begin
        // Unused order codes fall back to BRG.
        res_d.slot0_level = lvl_d[2];
        res_d.slot1_level = lvl_d[0];
        res_d.slot2_level = lvl_d[1];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      out_q <= res_d;
    end
  end

  assign rgb_o.valid   = v4_q;
  assign rgb_o.payload = out_q;

  // ---------------- Assertions

  // The reciprocal estimate is never more than one below the true quotient.
  a_est_one_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !err3_q |-> (rem_d[0] < (LEVEL_DIV << 1)) && (rem_d[1] < (LEVEL_DIV << 1))
                        && (rem_d[2] < (LEVEL_DIV << 1)))
    else $error("reciprocal estimate off by more than one");

  // An input stall only happens when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !hsv_i.ready |-> v1_q && v2_q && v3_q && v4_q)
    else $error("input stalled with a free pipeline stage");

  // A flagged result carries no level.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.valid && rgb_o.payload.range_error |->
      (rgb_o.payload.red_level == '0) && (rgb_o.payload.green_level == '0)
      && (rgb_o.payload.blue_level == '0) && (rgb_o.payload.slot0_level == '0)
      && (rgb_o.payload.slot1_level == '0) && (rgb_o.payload.slot2_level == '0))
    else $error("range error with nonzero level");

  // The first slot always holds one of the three color levels.
  a_slot_perm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rgb_o.valid |->
      (rgb_o.payload.slot0_level == rgb_o.payload.red_level)
      || (rgb_o.payload.slot0_level == rgb_o.payload.green_level)
      || (rgb_o.payload.slot0_level == rgb_o.payload.blue_level))
    else $error("slot level is not one of the color levels");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the HSV to RGB converter with LED channel ordering.
// Needs hsvrgb_pkg, hsvrgb_in_if, hsvrgb_out_if and hsv_to_rgb_channel_order_top.
// Predicts every result beat in SystemVerilog and checks it against the block's output.
module testbench;
  import hsvrgb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HueSpan    = 360;
  localparam int unsigned PctFull    = 100;
  localparam int unsigned SectorDeg  = 60;
  localparam int unsigned LevelTop   = 255;
  localparam int unsigned Scale60    = 600000;
  localparam int unsigned PipeDepth  = 4;
  localparam int unsigned RandItems  = 650;
  localparam int unsigned MaxReports = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [OrderW-1:0] cfg_wdata;

  hsvrgb_in_if  hsv_ch ();
  hsvrgb_out_if rgb_ch ();

  hsv_to_rgb_channel_order_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .hsv_i       (hsv_ch),
    .rgb_o       (rgb_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Shadow of the channel order register, updated when a write lands.
  logic [OrderW-1:0] order_now = '0;
  logic              full_rate = 1'b0;
  rgb_item_t         pending_rgb[$];
  int unsigned       beats_sent = 0;
  int unsigned       beats_checked = 0;
  int unsigned       mismatches = 0;
  int unsigned       range_errors_seen = 0;
  bit [7:0]          orders_used = '0;

  function automatic logic [LevelW-1:0] scale_to_level(logic [SumW-1:0] sum60);
    logic [31:0] wide;
    wide = 32'(sum60) * LevelTop;
    return LevelW'(wide / Scale60);
  endfunction

  function automatic rgb_item_t convert_hsv(hsv_item_t item, logic [OrderW-1:0] order);
    rgb_item_t        res;
    logic [ProdW-1:0] chroma;
    logic [ProdW-1:0] floor_m;
    logic [6:0]       hue_mod;
    logic [TW-1:0]    hue_dist;
    logic [TW-1:0]    tri_term;
    logic [SumW-1:0]  cm;
    logic [SumW-1:0]  xm;
    logic [SumW-1:0]  mm;
    logic [2:0]       sec;
    logic [LevelW-1:0] r;
    logic [LevelW-1:0] g;
    logic [LevelW-1:0] b;
    res = '0;
    r = '0;
    g = '0;
    b = '0;
    res.led_group = item.led_index;
    if (item.hue_degrees >= HueSpan || item.saturation_pct > PctFull ||
        item.value_pct > PctFull) begin
      res.range_error = 1'b1;
    end else begin
      chroma   = item.saturation_pct * item.value_pct;
      floor_m  = ProdW'(PctFull) * item.value_pct - chroma;
      hue_mod  = 7'(item.hue_degrees % (2 * SectorDeg));
      hue_dist = (hue_mod >= SectorDeg) ? TW'(hue_mod - SectorDeg) : TW'(SectorDeg - hue_mod);
      tri_term = TW'(SectorDeg) - hue_dist;
      // Sums carry a factor of 60 so the x term stays exact.
      cm  = SumW'(SectorDeg) * (chroma + floor_m);
      xm  = chroma * tri_term + SumW'(SectorDeg) * floor_m;
      mm  = SumW'(SectorDeg) * floor_m;
      sec = 3'(item.hue_degrees / SectorDeg);
      case (sec)
        SEC_R_TO_Y: begin r = scale_to_level(cm); g = scale_to_level(xm); b = scale_to_level(mm); end
        SEC_Y_TO_G: begin r = scale_to_level(xm); g = scale_to_level(cm); b = scale_to_level(mm); end
        SEC_G_TO_C: begin r = scale_to_level(mm); g = scale_to_level(cm); b = scale_to_level(xm); end
        SEC_C_TO_B: begin r = scale_to_level(mm); g = scale_to_level(xm); b = scale_to_level(cm); end
        SEC_B_TO_M: begin r = scale_to_level(xm); g = scale_to_level(mm); b = scale_to_level(cm); end
        default:    begin r = scale_to_level(cm); g = scale_to_level(mm); b = scale_to_level(xm); end
      endcase
    end
    res.red_level   = r;
    res.green_level = g;
    res.blue_level  = b;
    // The two unused codes fall back to blue, red, green.
    case (order)
      ORDER_RGB: begin res.slot0_level = r; res.slot1_level = g; res.slot2_level = b; end
      ORDER_RBG: begin res.slot0_level = r; res.slot1_level = b; res.slot2_level = g; end
      ORDER_GRB: begin res.slot0_level = g; res.slot1_level = r; res.slot2_level = b; end
      ORDER_GBR: begin res.slot0_level = g; res.slot1_level = b; res.slot2_level = r; end
      ORDER_BGR: begin res.slot0_level = b; res.slot1_level = g; res.slot2_level = r; end
      default:   begin res.slot0_level = b; res.slot1_level = r; res.slot2_level = g; end
    endcase
    return res;
  endfunction

  function automatic hsv_item_t make_hsv(int unsigned hue, int unsigned sat,
                                         int unsigned val, int unsigned grp);
    hsv_item_t item;
    item.hue_degrees    = HueW'(hue);
    item.saturation_pct = PctW'(sat);
    item.value_pct      = PctW'(val);
    item.led_index      = GrpW'(grp);
    return item;
  endfunction

  // Sends one beat and records its expected result once it is accepted.
  // Called at a rising edge; valid stays high afterwards for a following beat.
  task automatic send_hsv(hsv_item_t item);
    hsv_ch.valid   <= 1'b1;
    hsv_ch.payload <= item;
    do @(posedge clk); while (!hsv_ch.ready);
    pending_rgb.push_back(convert_hsv(item, order_now));
    beats_sent++;
  endtask

  task automatic pause_sender(int unsigned cycles);
    hsv_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    hsv_ch.valid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  task automatic write_order(logic [OrderW-1:0] order);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= order;
    @(posedge clk);
    cfg_we    <= 1'b0;
    order_now = order;
    orders_used[order] = 1'b1;
    @(posedge clk);
  endtask

  function automatic int unsigned rand_pct();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return PctFull;
      2:       return $urandom_range(PctFull - 5, PctFull);
      default: return $urandom_range(0, PctFull);
    endcase
  endfunction

  function automatic hsv_item_t rand_hsv();
    int unsigned hue;
    int unsigned sat;
    int unsigned val;
    int unsigned grp;
    int signed   near;
    grp = $urandom_range(0, 7);
    sat = rand_pct();
    val = rand_pct();
    if ($urandom_range(0, 4) == 0) begin
      // Land on or next to a sector boundary.
      near = $urandom_range(0, 5) * SectorDeg + $urandom_range(0, 2) - 1;
      hue  = (near < 0) ? HueSpan - 1 : near;
    end else begin
      hue = $urandom_range(0, HueSpan - 1);
    end
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 3))
        0:       hue = $urandom_range(HueSpan, 511);
        1:       sat = $urandom_range(PctFull + 1, 127);
        2:       val = $urandom_range(PctFull + 1, 127);
        default: begin
          hue = $urandom_range(0, 511);
          sat = $urandom_range(0, 127);
          val = $urandom_range(0, 127);
        end
      endcase
    end
    return make_hsv(hue, sat, val, grp);
  endfunction

  // Result checker: every accepted result beat is matched to the oldest prediction.
  always @(posedge clk) begin
    rgb_item_t want;
    rgb_item_t got;
    bit        bad;
    if (rst_n && rgb_ch.valid && rgb_ch.ready) begin
      got = rgb_ch.payload;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result beat: %p", got);
      end else begin
        want = pending_rgb.pop_front();
        beats_checked++;
        if (got.range_error) range_errors_seen++;
        bad = (got.range_error !== want.range_error) ||
              (got.led_group   !== want.led_group)   ||
              (got.red_level   !== want.red_level)   ||
              (got.green_level !== want.green_level) ||
              (got.blue_level  !== want.blue_level)  ||
              (got.slot0_level !== want.slot0_level) ||
              (got.slot1_level !== want.slot1_level) ||
              (got.slot2_level !== want.slot2_level);
        if (bad) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch at beat %0d: expected %p, got %p", beats_checked, want, got);
        end
      end
    end
  end

  // Receiver: ready follows a 16-bit pattern that is redrawn every pass, or stays high at full rate.
  initial begin
    logic [15:0] stall_pattern;
    int unsigned phase;
    rgb_ch.ready <= 1'b0;
    stall_pattern = '1;
    phase = 0;
    forever begin
      @(posedge clk);
      if (phase == 0) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern = '1;
          1:       stall_pattern = 16'($urandom) | 16'h0001;
          2:       stall_pattern = 16'($urandom & $urandom) | 16'h0001;
          default: stall_pattern = 16'($urandom | $urandom) | 16'h0001;
        endcase
      end
      rgb_ch.ready <= full_rate ? 1'b1 : stall_pattern[phase];
      phase = (phase + 1) % 16;
    end
  end

  task automatic test_reset_order();
    // After reset the order must be RGB without any write.
    send_hsv(make_hsv(0, 100, 100, 0));
    send_hsv(make_hsv(120, 100, 100, 1));
    send_hsv(make_hsv(240, 100, 100, 2));
    wait_drained();
  endtask

  task automatic test_field_extremes();
    int unsigned sector;
    write_order(ORDER_RGB);
    send_hsv(make_hsv(0, 0, 0, 0));
    send_hsv(make_hsv(359, 100, 100, 7));
    send_hsv(make_hsv(0, 0, 100, 5));
    send_hsv(make_hsv(200, 100, 0, 3));
    for (sector = 0; sector < 6; sector++) begin
      send_hsv(make_hsv(sector * SectorDeg, 100, 100, sector));
      send_hsv(make_hsv(sector * SectorDeg + 30, 73, 91, sector + 1));
    end
    send_hsv(make_hsv(59, 100, 100, 1));
    // Out-of-range hue, saturation and value, alone and together.
    send_hsv(make_hsv(360, 50, 50, 6));
    send_hsv(make_hsv(511, 100, 100, 7));
    send_hsv(make_hsv(10, 101, 50, 2));
    send_hsv(make_hsv(10, 127, 50, 3));
    send_hsv(make_hsv(10, 50, 101, 4));
    send_hsv(make_hsv(10, 50, 127, 5));
    send_hsv(make_hsv(511, 127, 127, 7));
    wait_drained();
  endtask

  task automatic test_channel_orders();
    int unsigned code;
    // All eight codes, including the two unused ones.
    for (code = 0; code < 8; code++) begin
      write_order(OrderW'(code));
      send_hsv(make_hsv(20, 80, 90, code));
      send_hsv(make_hsv(200, 60, 70, 7 - code));
    end
    wait_drained();
  endtask

  task automatic test_random_stream();
    int unsigned phase_idx;
    int unsigned left;
    int unsigned burst;
    int unsigned per_phase;
    per_phase = RandItems / 5;
    for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
      case (phase_idx)
        0:       write_order(ORDER_BRG);
        1:       write_order(3'd7);
        default: write_order(OrderW'($urandom_range(0, 7)));
      endcase
      full_rate = (phase_idx == 2);
      left = per_phase;
      while (left > 0) begin
        burst = $urandom_range(1, 24);
        if (burst > left) burst = left;
        repeat (burst) send_hsv(rand_hsv());
        left -= burst;
        if (!full_rate && $urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      wait_drained();
      full_rate = 1'b0;
    end
  endtask

  initial begin
    hsv_ch.valid   <= 1'b0;
    hsv_ch.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    orders_used[ORDER_RGB] = 1'b1;

    test_reset_order();
    test_field_extremes();
    test_channel_orders();
    test_random_stream();

    wait_drained();
    if (pending_rgb.size() != 0) mismatches++;
    $display("sent %0d HSV beats, checked %0d results, %0d of them range errors",
             beats_sent, beats_checked, range_errors_seen);
    $display("channel order codes exercised: %b, mismatches: %0d", orders_used, mismatches);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d results still outstanding", pending_rgb.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
